@@ rtl/tks_pkg.sv @@
`timescale 1ns / 1ps
// tks_pkg: shared types and constants for the top-k score table.
// Used by tks_ctrl, tks_datapath and top_k_score_table_core.
package tks_pkg;

  localparam int DEPTH_DEF = 10;
  localparam int SCORE_W   = 32;
  localparam int RANK_W    = 4;

  localparam logic OP_READ   = 1'b0;
  localparam logic OP_SUBMIT = 1'b1;

  typedef struct packed {
    logic                      op;
    logic signed [SCORE_W-1:0] score;
  } in_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] entry_score;
    logic [RANK_W-1:0]         rank;
    logic                      last;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SUBMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_read;
    logic scan_submit;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
  } sts_t;

endpackage

@@ rtl/tks_ctrl.sv @@
`timescale 1ns / 1ps
// tks_ctrl: sequencer for the score table; issues load and scan commands.
// Depends on tks_pkg.
module tks_ctrl
  import tks_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic op,
  input  sts_t sts,
  output logic busy,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (op == OP_SUBMIT) ? ST_SUBMIT : ST_READ;
        end
      end
      ST_READ, ST_SUBMIT: begin
        if (sts.idx_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy            = 1'b1;
    cmd             = '0;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_READ:   cmd.scan_read   = 1'b1;
      ST_SUBMIT: cmd.scan_submit = 1'b1;
      default:   busy            = 1'b0;
    endcase
  end

endmodule

@@ rtl/tks_datapath.sv @@
`timescale 1ns / 1ps
// tks_datapath: circular score table, one compare per cycle, result register.
// Depends on tks_pkg.
module tks_datapath
  import tks_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t cmd,
  input  in_t  in_data,
  output sts_t sts,
  output logic out_valid,
  output out_t out_data
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 2);

  logic [SCORE_W-1:0]        tbl_r [DEPTH];
  logic signed [SCORE_W-1:0] score_r;
  logic [SCORE_W-1:0]        carry_r;
  logic                      placed_r;
  logic [IDX_W-1:0]          idx_r;
  logic [IDX_W-1:0]          pos_r;
  logic                      out_valid_r;
  out_t                      out_r;

  logic [SCORE_W-1:0] head;
  logic               hit;
  logic               scan;
  logic [SCORE_W-1:0] tail_nxt;
  logic [CNT_W-1:0]   idx_plus1;
  logic [CNT_W-1:0]   rank_sub;

  assign head      = tbl_r[0];
  assign scan      = cmd.scan_read | cmd.scan_submit;
  assign hit       = !placed_r && ((head == '0) || ($signed(head) <= score_r));
  assign idx_plus1 = CNT_W'(idx_r) + CNT_W'(1);
  assign sts.idx_last = (idx_r == IDX_W'(DEPTH - 1));

  always_comb begin
    tail_nxt = head;
    if (cmd.scan_submit) begin
      if (hit) begin
        tail_nxt = score_r;
      end else if (placed_r) begin
        tail_nxt = carry_r;
      end
    end
  end

  always_comb begin
    if (placed_r) begin
      rank_sub = CNT_W'(pos_r) + CNT_W'(1);
    end else if (hit) begin
      rank_sub = idx_plus1;
    end else begin
      rank_sub = CNT_W'(DEPTH + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        tbl_r[i] <= '0;
      end
      placed_r    <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cmd.load) begin
        placed_r <= 1'b0;
        idx_r    <= '0;
      end else if (scan) begin
        for (int i = 0; i < DEPTH - 1; i++) begin
          tbl_r[i] <= tbl_r[i+1];
        end
        tbl_r[DEPTH-1] <= tail_nxt;
        idx_r          <= sts.idx_last ? '0 : idx_r + IDX_W'(1);
        if (cmd.scan_submit && hit) begin
          placed_r <= 1'b1;
        end
        out_valid_r <= cmd.scan_read | (cmd.scan_submit & sts.idx_last);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      score_r <= in_data.score;
    end
    if (cmd.scan_submit && (hit || placed_r)) begin
      carry_r <= head;
    end
    if (cmd.scan_submit && hit) begin
      pos_r <= idx_r;
    end
    if (cmd.scan_read) begin
      out_r.entry_score <= head;
      out_r.rank        <= RANK_W'(idx_plus1);
      out_r.last        <= sts.idx_last;
    end else if (cmd.scan_submit) begin
      out_r.entry_score <= '0;
      out_r.rank        <= RANK_W'(rank_sub);
      out_r.last        <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/top_k_score_table_core.sv @@
`timescale 1ns / 1ps
// top_k_score_table_core: descending top-DEPTH score table with rank reporting.
// Depends on tks_pkg, tks_ctrl and tks_datapath.
//
//   channel  ports                        transfer when
//   input    start, busy, in_data (in_t)  start && !busy
//   result   out_valid, out_data (out_t)  out_valid (one cycle, no stall)
//
// Each item is the transfer cycle, then a scan in which the table rotates
// through one compare stage, one entry per cycle, over all DEPTH entries.
// A read gives DEPTH results, one per cycle, each in the cycle after its
// entry passes the head. A submit gives one result in the cycle after the scan.
// Synchronous reset clears the table to empty. The receiver cannot stall;
// busy drops as the last result is registered.
module top_k_score_table_core
  import tks_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  cmd_t cmd;
  sts_t sts;

  tks_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_data.op),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  tks_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after transfer");

  a_out_near_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (busy || $past(busy)))
    else $error("result outside an item");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last) |=> !out_valid)
    else $error("result right after last");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.scan_read, cmd.scan_submit}))
    else $error("overlapping commands");

endmodule
